// ===== rtl/core/csr_pkg.sv =====
// Package: shared types, constants and command codes of the canvas shape rasterizer.
`default_nettype none
package csr_pkg;
  localparam int MaxColumns = 64;
  localparam int MaxRows    = 64;
  localparam int RowW       = $clog2(MaxRows);

  typedef enum logic [1:0] {
    ACT_SQUARE = 2'd0, ACT_LINE = 2'd1, ACT_TRI = 2'd2, ACT_READ = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0, ST_RANGE = 2'd1, ST_NOT_OCT = 2'd2
  } status_e;

  localparam logic [1:0] FaceLeft = 2'd1;
  localparam logic [1:0] FaceRight = 2'd2;
  localparam logic [1:0] FaceUp = 2'd1;
  localparam logic [1:0] FaceDown = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_CHECK, S_DRAW, S_READ, S_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture request
    logic sqrt_step; // one root iteration
    logic check;     // evaluate range checks, set up first segment
    logic draw_step; // mark one cell or one square row
    logic read;      // fetch row
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic reject;
    logic draw_done;
  } sts_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  x0;
    logic [7:0]  y0;
    logic [7:0]  x1;
    logic [7:0]  y1;
    logic [7:0]  size;
    logic [1:0]  face_horizontal;
    logic [1:0]  face_vertical;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] row_bits;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/csr_if.sv =====
// Interfaces: valid/ready channels for requests and responses.
`default_nettype none
interface csr_req_if;
  logic valid;
  logic ready;
  csr_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csr_rsp_if;
  logic valid;
  logic ready;
  csr_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/csr_ctrl.sv =====
// Controller: sequences one request through root, check, draw and response.
`default_nettype none
module csr_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic [1:0]   action_i,
  input  wire csr_pkg::sts_t sts_i,
  output csr_pkg::cmd_t     cmd_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i
);
  csr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      csr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (action_i == csr_pkg::ACT_TRI) state_d = csr_pkg::S_SQRT;
          else if (action_i == csr_pkg::ACT_READ) state_d = csr_pkg::S_READ;
          else state_d = csr_pkg::S_CHECK;
        end
      end
      csr_pkg::S_SQRT: if (sts_i.sqrt_done) state_d = csr_pkg::S_CHECK;
      csr_pkg::S_CHECK: state_d = csr_pkg::S_DRAW;
      csr_pkg::S_DRAW: if (sts_i.reject || sts_i.draw_done) state_d = csr_pkg::S_OUT;
      csr_pkg::S_READ: state_d = csr_pkg::S_OUT;
      csr_pkg::S_OUT: if (out_ready_i) state_d = csr_pkg::S_IDLE;
      default: state_d = csr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      csr_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      csr_pkg::S_SQRT: cmd_o.sqrt_step = 1'b1;
      csr_pkg::S_CHECK: cmd_o.check = 1'b1;
      csr_pkg::S_DRAW: cmd_o.draw_step = !sts_i.reject;
      csr_pkg::S_READ: cmd_o.read = 1'b1;
      csr_pkg::S_OUT: out_valid_o = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csr_pkg::S_OUT && !out_ready_i) |=> state_q == csr_pkg::S_OUT)
    else $error("response dropped under stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while response pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.sqrt_step, cmd_o.check, cmd_o.draw_step, cmd_o.read}) <= 1)
    else $error("conflicting datapath commands");
endmodule
`default_nettype wire

// ===== rtl/core/csr_dp.sv =====
// Datapath: canvas memory, square root unit, range checks and line stepper.
`default_nettype none
module csr_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [6:0]    cfg_data_i,
  input  wire csr_pkg::req_t req_i,
  input  wire csr_pkg::cmd_t cmd_i,
  output csr_pkg::sts_t      sts_o,
  output csr_pkg::rsp_t      rsp_o
);
  logic [6:0] width_q, height_q;
  logic [63:0] canvas_q [csr_pkg::MaxRows];
  logic [csr_pkg::MaxRows-1:0] vld_q;
  csr_pkg::req_t r_q;
  logic [7:0] root_q;
  logic [14:0] half_q;
  logic [1:0] status_q;
  logic [63:0] bits_q;
  // stepper: segment index, current point, end point
  logic [1:0] seg_q;
  logic signed [9:0] cx_q, cy_q, ex_q, ey_q;
  logic signed [9:0] xa_q, yb_q;
  logic [6:0] rows_left_q;
  logic done_q, reject_q;
  // row fetch phase and fetched row
  logic ph_q;
  logic [63:0] rd_q;
  logic rdv_q;

  logic [6:0] w_eff, h_eff;
  assign w_eff = (width_q > 7'(csr_pkg::MaxColumns)) ? 7'(csr_pkg::MaxColumns) : width_q;
  assign h_eff = (height_q > 7'(csr_pkg::MaxRows)) ? 7'(csr_pkg::MaxRows) : height_q;

  function automatic logic ins(input logic signed [9:0] x, input logic signed [9:0] y,
                               input logic [6:0] w, input logic [6:0] h);
    ins = (x >= 0) && (x < $signed({3'b0, w})) && (y >= 0) && (y < $signed({3'b0, h}));
  endfunction

  logic signed [9:0] x0s, y0s, x1s, y1s, sz, len, xa, yb, adx, ady;
  logic [63:0] sq_mask;
  logic [15:0] size_sq;
  logic [8:0] r1;
  logic [17:0] r1sq;
  logic sq_bad, ln_out, ln_oct, tr_bad;
  logic row_hit, mark_ok, fetch;
  logic [63:0] wr_row, wmask;
  logic [csr_pkg::RowW-1:0] wr_idx;
  logic signed [9:0] sx, sy;
  logic at_end;

  always_comb begin
    x0s = 10'(signed'(r_q.x0)); y0s = 10'(signed'(r_q.y0));
    x1s = 10'(signed'(r_q.x1)); y1s = 10'(signed'(r_q.y1));
    sz = $signed({2'b0, r_q.size});
    len = $signed({2'b0, root_q});
    xa = (r_q.face_horizontal == csr_pkg::FaceLeft) ? x0s - len :
         (r_q.face_horizontal == csr_pkg::FaceRight) ? x0s + len : x0s;
    yb = (r_q.face_vertical == csr_pkg::FaceUp) ? y0s - len :
         (r_q.face_vertical == csr_pkg::FaceDown) ? y0s + len : y0s;
    adx = (x1s > x0s) ? x1s - x0s : x0s - x1s;
    ady = (y1s > y0s) ? y1s - y0s : y0s - y1s;
    sq_bad = (r_q.size == 8'd0) || (x0s < 0) || (y0s < 0) ||
             (x0s + sz > $signed({3'b0, w_eff})) || (y0s + sz > $signed({3'b0, h_eff}));
    ln_out = !ins(x0s, y0s, w_eff, h_eff) || !ins(x1s, y1s, w_eff, h_eff);
    ln_oct = (adx == 0) || (ady == 0) || (adx == ady);
    tr_bad = (r_q.size == 8'd0) || !ins(x0s, y0s, w_eff, h_eff) ||
             !ins(xa, y0s, w_eff, h_eff) || !ins(x0s, yb, w_eff, h_eff);
    sq_mask = ((r_q.size >= 8'd64) ? {64{1'b1}} : ((64'd1 << r_q.size[5:0]) - 64'd1))
              << x0s[5:0];
    size_sq = r_q.size * r_q.size;
    r1 = {1'b0, root_q} + 9'd1;
    r1sq = r1 * r1;
    sx = (ex_q > cx_q) ? 10'sd1 : (ex_q < cx_q) ? -10'sd1 : 10'sd0;
    sy = (ey_q > cy_q) ? 10'sd1 : (ey_q < cy_q) ? -10'sd1 : 10'sd0;
    at_end = (cx_q == ex_q) && (cy_q == ey_q);
  end

  // each canvas row is fetched into a register, then written back merged;
  // valid bits stand in for reset clearing
  always_comb begin
    if (r_q.action == csr_pkg::ACT_SQUARE) begin
      wr_idx = cy_q[csr_pkg::RowW-1:0];
      wmask = sq_mask;
    end else begin
      wr_idx = cy_q[csr_pkg::RowW-1:0];
      wmask = 64'd1 << cx_q[5:0];
    end
    wr_row = (rdv_q ? rd_q : 64'd0) | wmask;
    fetch = cmd_i.draw_step && !done_q && !ph_q;
    mark_ok = cmd_i.draw_step && !done_q && ph_q;
    row_hit = vld_q[r_q.y0[csr_pkg::RowW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 7'd64;
      height_q <= 7'd64;
      vld_q <= '0;
      done_q <= 1'b0;
      reject_q <= 1'b0;
      ph_q <= 1'b0;
      rdv_q <= 1'b0;
    end else begin
      if (cfg_we_i && !cfg_idx_i) width_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i) height_q <= cfg_data_i;
      if (cmd_i.load) begin
        done_q <= 1'b0;
        reject_q <= 1'b0;
        ph_q <= 1'b0;
      end
      if (cmd_i.check) begin
        case (r_q.action)
          csr_pkg::ACT_SQUARE: reject_q <= sq_bad;
          csr_pkg::ACT_LINE: reject_q <= ln_out || !ln_oct;
          default: reject_q <= tr_bad;
        endcase
      end
      if (fetch) begin
        ph_q <= 1'b1;
        rdv_q <= vld_q[wr_idx];
      end
      if (mark_ok) begin
        ph_q <= 1'b0;
        vld_q[wr_idx] <= 1'b1;
        if (r_q.action == csr_pkg::ACT_SQUARE) begin
          if (rows_left_q == 7'd1) done_q <= 1'b1;
        end else if (at_end && (r_q.action != csr_pkg::ACT_TRI || seg_q == 2'd2)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_ok) canvas_q[wr_idx] <= wr_row;
    if (fetch) rd_q <= canvas_q[wr_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r_q <= req_i;
      root_q <= '0;
      half_q <= '0;
      status_q <= csr_pkg::ST_DONE;
      bits_q <= '0;
    end
    if (cmd_i.sqrt_step) begin
      half_q <= size_sq[15:1];
      if (half_q == size_sq[15:1] && {3'b0, r1sq[14:0]} <= {3'b0, half_q} && r1sq[17:15] == 0)
        root_q <= r1[7:0];
    end
    if (cmd_i.check) begin
      seg_q <= 2'd0;
      rows_left_q <= {1'b0, r_q.size[5:0]} | {r_q.size[6], 6'b0};
      cx_q <= x0s; cy_q <= y0s;
      case (r_q.action)
        csr_pkg::ACT_SQUARE: begin
          if (sq_bad) status_q <= csr_pkg::ST_RANGE;
        end
        csr_pkg::ACT_LINE: begin
          ex_q <= x1s; ey_q <= y1s;
          if (ln_out) status_q <= csr_pkg::ST_RANGE;
          else if (!ln_oct) status_q <= csr_pkg::ST_NOT_OCT;
        end
        default: begin
          ex_q <= xa; ey_q <= y0s; xa_q <= xa; yb_q <= yb;
          if (tr_bad) status_q <= csr_pkg::ST_RANGE;
        end
      endcase
    end
    if (mark_ok) begin
      if (r_q.action == csr_pkg::ACT_SQUARE) begin
        cy_q <= cy_q + 10'sd1;
        rows_left_q <= rows_left_q - 7'd1;
      end else if (!at_end) begin
        cx_q <= cx_q + sx; cy_q <= cy_q + sy;
      end else begin
        seg_q <= seg_q + 2'd1;
        if (seg_q == 2'd0) begin
          cx_q <= x0s; cy_q <= y0s; ex_q <= x0s; ey_q <= yb_q;
        end else begin
          cx_q <= xa_q; cy_q <= y0s; ex_q <= x0s; ey_q <= yb_q;
        end
      end
    end
    if (cmd_i.read) begin
      if (y0s < 0 || y0s >= $signed({3'b0, h_eff}) || w_eff == 7'd0) begin
        status_q <= csr_pkg::ST_RANGE;
      end else begin
        bits_q <= (row_hit ? canvas_q[r_q.y0[csr_pkg::RowW-1:0]] : 64'd0) &
                  ((w_eff >= 7'd64) ? {64{1'b1}} : ((64'd1 << w_eff[5:0]) - 64'd1));
      end
    end
  end

  // root search ends once (root+1)^2 exceeds the half square
  assign sts_o.sqrt_done = (half_q == size_sq[15:1]) &&
                           ({3'b0, r1sq[14:0]} > {3'b0, half_q} || r1sq[17:15] != 0);
  assign sts_o.reject = reject_q;
  assign sts_o.draw_done = done_q;
  assign rsp_o.status = status_q;
  assign rsp_o.row_bits = bits_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_step |-> !reject_q)
    else $error("draw on rejected request");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mark_ok && r_q.action != csr_pkg::ACT_SQUARE) |-> cx_q >= 0 && cx_q < 64)
    else $error("stepper left the canvas");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.draw_step |-> status_q == csr_pkg::ST_DONE)
    else $error("draw with error status");
endmodule
`default_nettype wire

// ===== rtl/core/canvas_shape_rasterizer.sv =====
// Top level: canvas shape rasterizer, controller plus datapath.
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        action x0 y0 x1 y1 size face_*
//  rsp      out  valid/ready        status row_bits
//  cfg      in   cfg_we_i           cfg_idx_i cfg_data_i (width, height)
//
// Steps: a read fetches its row, a square or line is checked then drawn, a triangle
// first searches its leg length (root search runs one candidate per cycle), then is
// checked and drawn over its three legs, a rejected draw marks nothing; each cell or
// square row costs a row fetch and a write back. Each command then holds its response until taken.
// Reset clears the canvas at once via per-row valid bits; no clearing pass.
// One request is in flight at a time; a stalled response blocks new requests.
`default_nettype none
module canvas_shape_rasterizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic [0:0] cfg_idx_i,
  input  wire logic [6:0] cfg_data_i,
  csr_req_if.sink   req,
  csr_rsp_if.source rsp
);
  csr_pkg::cmd_t cmd;
  csr_pkg::sts_t sts;

  // controller owns the handshake
  csr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req.valid), .in_ready_o (req.ready),
    .action_i   (req.data.action),
    .sts_i      (sts), .cmd_o (cmd),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready)
  );

  // datapath holds canvas, registers and response
  csr_dp u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i (cfg_idx_i[0]), .cfg_data_i,
    .req_i (req.data), .cmd_i (cmd), .sts_o (sts), .rsp_o (rsp.data)
  );
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Testbench for canvas_shape_rasterizer: random and directed commands against a canvas predictor.
`timescale 1ns / 1ps
module tb;
  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [6:0] cfg_data_i = '0;

  localparam int unsigned IdleLimit = 20000;

  csr_req_if req_ch ();
  csr_rsp_if rsp_ch ();

  canvas_shape_rasterizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predicted canvas and register copies
  logic [63:0] shadow_canvas [csr_pkg::MaxRows];
  logic [6:0]  shadow_width;
  logic [6:0]  shadow_height;

  csr_pkg::req_t pending_cmds [$];
  csr_pkg::rsp_t expected_rsps [$];

  int unsigned mismatches   = 0;
  int unsigned cmds_sent    = 0;
  int unsigned rsps_checked = 0;
  int unsigned idle_cycles  = 0;
  int unsigned status_seen [3] = '{0, 0, 0};

  // Knobs driven by the stimulus process
  bit          no_gaps     = 1'b0;
  bit          send_pause  = 1'b0;
  int unsigned rsp_holdoff = 0;

  logic req_fire = 1'b0;
  logic rsp_fire = 1'b0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;

  function automatic int eff_width();
    return (shadow_width > csr_pkg::MaxColumns) ? csr_pkg::MaxColumns : int'(shadow_width);
  endfunction

  function automatic int eff_height();
    return (shadow_height > csr_pkg::MaxRows) ? csr_pkg::MaxRows : int'(shadow_height);
  endfunction

  function automatic bit on_canvas(int x, int y);
    return x >= 0 && x < eff_width() && y >= 0 && y < eff_height();
  endfunction

  function automatic logic [63:0] ones_below(int n);
    if (n <= 0) return '0;
    if (n >= 64) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  function automatic void plot(int x, int y);
    if (x >= 0 && x < 64 && y >= 0 && y < csr_pkg::MaxRows) shadow_canvas[y][x] = 1'b1;
  endfunction

  function automatic int step_toward(int a, int b);
    return (a < b) ? 1 : ((a > b) ? -1 : 0);
  endfunction

  // Walk from (xa,ya) to (xb,yb), marking both ends
  function automatic void trace_segment(int xa, int ya, int xb, int yb);
    int sx;
    int sy;
    int n;
    sx = step_toward(xa, xb);
    sy = step_toward(ya, yb);
    n = 0;
    while ((xa != xb || ya != yb) && n < 512) begin
      plot(xa, ya);
      xa += sx;
      ya += sy;
      n++;
    end
    plot(xb, yb);
  endfunction

  function automatic int floor_root(int v);
    int r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  // Apply one command to the shadow canvas and return its response
  function automatic csr_pkg::rsp_t paint_command(csr_pkg::req_t c);
    csr_pkg::rsp_t res;
    int x0;
    int y0;
    int x1;
    int y1;
    int sz;
    int w;
    int h;
    int dx;
    int dy;
    int leg;
    int xa;
    int yb;
    x0 = int'($signed(c.x0));
    y0 = int'($signed(c.y0));
    x1 = int'($signed(c.x1));
    y1 = int'($signed(c.y1));
    sz = int'(c.size);
    w = eff_width();
    h = eff_height();
    res.status = csr_pkg::ST_DONE;
    res.row_bits = '0;
    case (csr_pkg::action_e'(c.action))
      csr_pkg::ACT_SQUARE: begin
        if (sz == 0 || x0 < 0 || y0 < 0 || x0 + sz > w || y0 + sz > h) begin
          res.status = csr_pkg::ST_RANGE;
        end else begin
          for (int r = y0; r < y0 + sz && r < csr_pkg::MaxRows; r++)
            shadow_canvas[r] |= ones_below(sz) << x0;
        end
      end
      csr_pkg::ACT_LINE: begin
        dx = (x1 > x0) ? x1 - x0 : x0 - x1;
        dy = (y1 > y0) ? y1 - y0 : y0 - y1;
        if (!on_canvas(x0, y0) || !on_canvas(x1, y1)) res.status = csr_pkg::ST_RANGE;
        else if (dx != 0 && dy != 0 && dx != dy) res.status = csr_pkg::ST_NOT_OCT;
        else trace_segment(x0, y0, x1, y1);
      end
      csr_pkg::ACT_TRI: begin
        if (sz == 0 || !on_canvas(x0, y0)) begin
          res.status = csr_pkg::ST_RANGE;
        end else begin
          leg = floor_root((sz * sz) / 2);
          xa = x0;
          yb = y0;
          if (c.face_horizontal == csr_pkg::FaceLeft) xa -= leg;
          else if (c.face_horizontal == csr_pkg::FaceRight) xa += leg;
          if (c.face_vertical == csr_pkg::FaceUp) yb -= leg;
          else if (c.face_vertical == csr_pkg::FaceDown) yb += leg;
          if (!on_canvas(xa, y0) || !on_canvas(x0, yb)) begin
            res.status = csr_pkg::ST_RANGE;
          end else begin
            trace_segment(x0, y0, xa, y0);
            trace_segment(x0, y0, x0, yb);
            trace_segment(xa, y0, x0, yb);
          end
        end
      end
      default: begin
        if (y0 < 0 || y0 >= h || w <= 0) res.status = csr_pkg::ST_RANGE;
        else res.row_bits = shadow_canvas[y0] & ones_below(w);
      end
    endcase
    return res;
  endfunction

  function automatic csr_pkg::req_t make_cmd(csr_pkg::action_e a, int x0, int y0, int x1,
                                             int y1, int sz, int fh, int fv);
    csr_pkg::req_t c;
    c.action = a;
    c.x0 = x0[7:0];
    c.y0 = y0[7:0];
    c.x1 = x1[7:0];
    c.y1 = y1[7:0];
    c.size = sz[7:0];
    c.face_horizontal = fh[1:0];
    c.face_vertical = fv[1:0];
    return c;
  endfunction

  // Coordinate mostly on the canvas, sometimes just off an edge
  function automatic int pick_coord(int extent);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? -1 : extent;
    return $urandom_range(0, (extent > 0) ? extent - 1 : 0);
  endfunction

  function automatic csr_pkg::req_t random_cmd();
    csr_pkg::req_t c;
    logic [63:0] raw;
    int w;
    int h;
    int x0;
    int y0;
    int len;
    int sx;
    int sy;
    int sz;
    w = eff_width();
    h = eff_height();
    // Some fully random requests so every field bit toggles
    if ($urandom_range(0, 9) == 0) begin
      raw = {$urandom(), $urandom()};
      c = raw[$bits(csr_pkg::req_t)-1:0];
      return c;
    end
    x0 = pick_coord(w);
    y0 = pick_coord(h);
    sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0: return make_cmd(csr_pkg::ACT_SQUARE, x0, y0, 0, 0, sz, 0, 0);
      1: begin
        len = $urandom_range(0, 12);
        sx = $urandom_range(0, 2) - 1;
        sy = $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 7) == 0)
          return make_cmd(csr_pkg::ACT_LINE, x0, y0, pick_coord(w), pick_coord(h), 0, 0, 0);
        return make_cmd(csr_pkg::ACT_LINE, x0, y0, x0 + sx * len, y0 + sy * len, 0, 0, 0);
      end
      2: return make_cmd(csr_pkg::ACT_TRI, x0, y0, 0, 0, sz, $urandom_range(0, 3),
                         $urandom_range(0, 3));
      default: return make_cmd(csr_pkg::ACT_READ, 0, pick_coord(h), 0, 0, 0, 0, 0);
    endcase
  endfunction

  // Sender: advance to the next request once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!req_ch.valid || req_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && !send_pause) begin
        req_ch.data <= pending_cmds.pop_front();
        req_ch.valid <= 1'b1;
        send_gap <= no_gaps ? 0 : $urandom_range(0, 15);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: hold ready low for the long hold-off, else per-response stalls
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_holdoff > 0) begin
        rsp_holdoff <= rsp_holdoff - 1;
        rsp_ch.ready <= 1'b0;
      end else if (rsp_fire) begin
        take_gap <= no_gaps ? 0 : $urandom_range(0, 15);
        rsp_ch.ready <= no_gaps;
      end else if (take_gap > 0) begin
        take_gap <= take_gap - 1;
        rsp_ch.ready <= (take_gap == 1);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each accepted request, check each accepted response
  always @(posedge clk_i) begin
    csr_pkg::rsp_t want;
    req_fire <= req_ch.valid && req_ch.ready;
    rsp_fire <= rsp_ch.valid && rsp_ch.ready;
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_rsps.push_back(paint_command(req_ch.data));
        cmds_sent++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response: status %0d row_bits %h",
                                         rsp_ch.data.status, rsp_ch.data.row_bits);
        end else begin
          want = expected_rsps.pop_front();
          rsps_checked++;
          if (want.status < 3) status_seen[want.status]++;
          if (rsp_ch.data.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) $display("status mismatch: expected %0d actual %0d",
                                           want.status, rsp_ch.data.status);
          end
          if (rsp_ch.data.row_bits !== want.row_bits) begin
            mismatches++;
            if (mismatches <= 10) $display("row_bits mismatch: expected %h actual %h",
                                           want.row_bits, rsp_ch.data.row_bits);
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no handshake for %0d cycles", IdleLimit);
      $display("** canvas_shape_rasterizer: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Wait until every queued request is taken and every response is back
  task automatic drain();
    while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write one register while idle and mirror it in the predictor
  task automatic write_reg(int idx, int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[0:0];
    cfg_data_i <= val[6:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == 0) shadow_width = val[6:0];
    else shadow_height = val[6:0];
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
  endtask

  initial begin
    int widths [6];
    int heights [6];
    widths = '{13, 1, 0, 127, 64, 40};
    heights = '{7, 1, 64, 100, 64, 0};
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    for (int r = 0; r < csr_pkg::MaxRows; r++) shadow_canvas[r] = '0;
    shadow_width = 7'd64;
    shadow_height = 7'd64;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every action, each rejection path
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_SQUARE, 0, 0, 0, 0, 1, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_SQUARE, 56, 56, 0, 0, 8, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_SQUARE, 57, 0, 0, 0, 8, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_SQUARE, 5, 5, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_SQUARE, -1, 3, 0, 0, 2, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_SQUARE, 0, 0, 0, 0, 255, 3, 3));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_LINE, 0, 10, 63, 10, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_LINE, 20, 63, 20, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_LINE, 63, 0, 0, 63, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_LINE, 30, 30, 30, 30, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_LINE, 1, 1, 4, 2, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_LINE, -128, 0, 127, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_TRI, 32, 32, 0, 0, 10,
                                    csr_pkg::FaceRight, csr_pkg::FaceDown));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_TRI, 40, 40, 0, 0, 7,
                                    csr_pkg::FaceLeft, csr_pkg::FaceUp));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_TRI, 10, 50, 0, 0, 5, 0, 3));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_TRI, 5, 5, 0, 0, 20, csr_pkg::FaceLeft, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_TRI, 5, 5, 0, 0, 0,
                                    csr_pkg::FaceRight, csr_pkg::FaceDown));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_TRI, 0, 0, 0, 0, 255,
                                    csr_pkg::FaceRight, csr_pkg::FaceDown));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_READ, 0, 10, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_READ, 0, 63, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_READ, 0, 64, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_READ, 0, -128, 0, 0, 0, 0, 0));
    pending_cmds.push_back(make_cmd(csr_pkg::ACT_READ, 0, 127, 0, 0, 0, 0, 0));
    drain();

    // Random phases over several canvas sizes; the drain between phases
    // is also the sender's pause until all responses are back
    for (int p = 0; p < 6; p++) begin
      write_reg(0, widths[p]);
      write_reg(1, heights[p]);
      no_gaps = (p == 4);
      queue_random(40);
      if (p == 3) begin
        // Long receiver hold-off while the sender keeps offering
        rsp_holdoff = 400;
      end
      queue_random(30);
      drain();
    end

    $display("ran %0d commands over 7 canvas settings: %0d done, %0d out of range,",
             cmds_sent, status_seen[0], status_seen[1]);
    $display("%0d non-octilinear lines; %0d responses checked, %0d mismatches",
             status_seen[2], rsps_checked, mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("** canvas_shape_rasterizer: PASSED **");
    end else begin
      $display("** canvas_shape_rasterizer: FAILED **");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/csr_pkg.sv
rtl/core/csr_if.sv
rtl/core/csr_ctrl.sv
rtl/core/csr_dp.sv
rtl/core/canvas_shape_rasterizer.sv
tb/sv/tb.sv
